// File: rtl/swm_pkg.sv
// ----------------------------------------------------------------------------
// swm_pkg
// Shared types and constants for the sliding-window median filter: sample
// type, cell-chain operations, sequencer states and the register map.
// ----------------------------------------------------------------------------
package swm_pkg;

    // Sample and register widths.
    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 7;
    localparam int APB_DW   = 32;
    localparam int APB_AW   = 3;

    // Window length after reset.
    localparam logic [WLEN_W-1:0] WLEN_RESET = 7'd3;

    // Register map: bit 2 of the byte address selects the register word.
    localparam logic REG_SEL_WINDOW_LENGTH = 1'b0;

    typedef logic signed [SAMPLE_W-1:0] t_sample;

    // Operation applied by every cell of the chain together.
    typedef enum logic [1:0] {
        OP_HOLD,
        OP_AGE,
        OP_DROP,
        OP_INSERT
    } t_op;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DROP,
        ST_INSERT,
        ST_EMIT
    } t_state;

    // Command broadcast from the sequencer to the cell chain.
    typedef struct packed {
        t_op     op;
        logic    restart;
        t_sample sample;
    } t_cmd;

endpackage

// File: rtl/swm_cell.sv
// ----------------------------------------------------------------------------
// swm_cell
// One cell of the sorted chain: holds one sample, its age and a valid bit.
// It ages, closes a gap by taking its right neighbor, or opens a gap for a
// new sample by taking its left neighbor, as the broadcast command says.
// ----------------------------------------------------------------------------
module swm_cell #(
    parameter int AGE_W = 7
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  swm_pkg::t_cmd        i_cmd,
    input  logic                 i_drop_found,
    input  swm_pkg::t_sample     i_drop_value,
    input  logic [AGE_W-1:0]     i_drop_age,
    input  swm_pkg::t_sample     i_left_value,
    input  logic [AGE_W-1:0]     i_left_age,
    input  logic                 i_left_valid,
    input  logic                 i_left_gt,
    input  swm_pkg::t_sample     i_right_value,
    input  logic [AGE_W-1:0]     i_right_age,
    input  logic                 i_right_valid,
    output swm_pkg::t_sample     o_value,
    output logic [AGE_W-1:0]     o_age,
    output logic                 o_valid,
    output logic                 o_gt
);
    import swm_pkg::*;

    t_sample          r_value;
    logic [AGE_W-1:0] r_age;
    logic             r_valid;
    t_sample          n_value;
    logic [AGE_W-1:0] n_age;
    logic             n_valid;
    logic             w_gt;
    logic             w_at_or_above_drop;

    // Greater than the sample being inserted.
    assign w_gt = r_valid && ($signed(r_value) > $signed(i_cmd.sample));

    // Among equal values the older sample sits further left, so the value
    // and the age together place this cell relative to the outgoing one.
    assign w_at_or_above_drop = !r_valid
        || ($signed(r_value) > $signed(i_drop_value))
        || ((r_value == i_drop_value) && (r_age <= i_drop_age));

    // Next contents of the cell.
    always_comb begin
        n_value = r_value;
        n_age   = r_age;
        n_valid = r_valid;
        case (i_cmd.op)
            OP_AGE: begin
                n_age = r_age + 1'b1;
                if (i_cmd.restart) begin
                    n_valid = 1'b0;
                end
            end
            OP_DROP: begin
                if (i_drop_found && w_at_or_above_drop) begin
                    n_value = i_right_value;
                    n_age   = i_right_age;
                    n_valid = i_right_valid;
                end
            end
            OP_INSERT: begin
                if (i_left_gt) begin
                    n_value = i_left_value;
                    n_age   = i_left_age;
                    n_valid = i_left_valid;
                end else if (i_left_valid && (!r_valid || w_gt)) begin
                    n_value = i_cmd.sample;
                    n_age   = '0;
                    n_valid = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // Only the valid bit needs a reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_age   <= n_age;
    end

    assign o_value = r_value;
    assign o_age   = r_age;
    assign o_valid = r_valid;
    assign o_gt    = w_gt;

endmodule

// File: rtl/swm_seq.sv
// ----------------------------------------------------------------------------
// swm_seq
// Sequencer of the median filter: takes one input word, steps the cell
// chain through age, drop and insert, and loads the output register.
// ----------------------------------------------------------------------------
module swm_seq #(
    parameter int KW = 7
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  swm_pkg::t_sample   i_sample,
    input  logic               i_restart,
    input  logic [KW-1:0]      i_k,
    output swm_pkg::t_cmd      o_cmd,
    output logic [KW-1:0]      o_drop_age,
    input  logic               i_have_result,
    input  swm_pkg::t_sample   i_median,
    output logic               o_valid,
    input  logic               i_ready,
    output swm_pkg::t_sample   o_median
);
    import swm_pkg::*;

    t_state        r_state;
    t_state        n_state;
    t_sample       r_sample;
    logic [KW-1:0] r_t;
    logic [KW-1:0] n_t;
    logic [KW-1:0] r_kprev;
    logic [KW-1:0] n_kprev;
    logic          r_out_valid;
    logic          n_out_valid;
    t_sample       r_out_median;
    logic          w_accept;
    logic          w_load;
    t_op           w_op;

    assign w_accept = i_valid && (r_state == ST_IDLE);

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = ST_DROP;
                end
            end
            ST_DROP: begin
                if (r_t <= i_k) begin
                    n_state = ST_INSERT;
                end
            end
            ST_INSERT: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (!i_have_result || !r_out_valid || i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Outputs of the state machine.
    always_comb begin
        w_op   = OP_HOLD;
        w_load = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    w_op = OP_AGE;
                end
            end
            ST_DROP: begin
                if (r_t >= i_k) begin
                    w_op = OP_DROP;
                end
            end
            ST_INSERT: begin
                w_op = OP_INSERT;
            end
            ST_EMIT: begin
                w_load = i_have_result && (!r_out_valid || i_ready);
            end
            default: begin
            end
        endcase
    end

    // The drop pass walks the ages from the previous window length down to
    // the current one; a restart empties the chain so nothing is dropped.
    always_comb begin
        n_t     = r_t;
        n_kprev = r_kprev;
        if (w_accept) begin
            n_t = i_restart ? '0 : r_kprev;
        end else if (r_state == ST_DROP) begin
            n_t = r_t - 1'b1;
        end
        if (r_state == ST_INSERT) begin
            n_kprev = i_k;
        end
    end

    // Output register.
    always_comb begin
        n_out_valid = r_out_valid;
        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_kprev     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_kprev     <= n_kprev;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_t <= n_t;
        if (w_accept) begin
            r_sample <= i_sample;
        end
        if (w_load) begin
            r_out_median <= i_median;
        end
    end

    assign o_ready       = (r_state == ST_IDLE);
    assign o_cmd.op      = w_op;
    assign o_cmd.restart = i_restart;
    assign o_cmd.sample  = r_sample;
    assign o_drop_age    = r_t;
    assign o_valid       = r_out_valid;
    assign o_median      = r_out_median;

endmodule

// File: rtl/sliding_window_median.sv
// Sliding-window median filter for signed 32-bit samples. Samples are kept in
// a chain of MAX_WINDOW cells sorted ascending, each tagged with its age. An
// input word passes through four steps: the cells are aged, the sample that
// leaves the window is dropped, the new sample is inserted in sorted
// position and the output register is loaded. When the window length is
// lower than for the previous word, the drop step of the next word removes
// one outgoing sample per cycle down to the new length, unless that word
// restarts the window.
// The emit cycle waits while an earlier result is still held and not taken.
// A result word comes once the window holds window_length samples; it is the
// median, the lower one for an even length. The window length register sits
// at byte address 0; zero acts as one and values above MAX_WINDOW saturate.
// ----------------------------------------------------------------------------
// sliding_window_median
// Top level: configuration port, cell chain, drop and median selection, and
// the sequencer.
// ----------------------------------------------------------------------------
module sliding_window_median #(
    parameter int MAX_WINDOW = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [31:0]          i_sample,
    input  logic                        i_restart,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic signed [31:0]          o_median,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [swm_pkg::APB_AW-1:0]  paddr,
    input  logic [swm_pkg::APB_DW-1:0]  pwdata,
    output logic [swm_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);
    import swm_pkg::*;

    localparam int KW = $clog2(MAX_WINDOW + 1);

    logic [WLEN_W-1:0] r_wlen;
    logic [KW-1:0]     w_k;
    logic [KW-1:0]     w_k_m1;
    logic [KW-1:0]     w_tap;
    t_cmd              w_cmd;
    logic [KW-1:0]     w_drop_age;
    logic              w_drop_found;
    t_sample           w_drop_value;
    t_sample           w_median;
    logic              w_have_result;

    t_sample           w_value [MAX_WINDOW];
    logic [KW-1:0]     w_age   [MAX_WINDOW];
    logic [MAX_WINDOW-1:0] w_valid;
    logic [MAX_WINDOW-1:0] w_gt;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen <= WLEN_RESET;
        end else if (psel && penable && pwrite && (paddr[2] == REG_SEL_WINDOW_LENGTH)) begin
            r_wlen <= pwdata[WLEN_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_SEL_WINDOW_LENGTH)
                  ? {{(APB_DW-WLEN_W){1'b0}}, r_wlen} : '0;

    // Effective window length and the rank of the median.
    always_comb begin
        if (r_wlen == '0) begin
            w_k = KW'(1);
        end else if (int'(r_wlen) > MAX_WINDOW) begin
            w_k = KW'(MAX_WINDOW);
        end else begin
            w_k = KW'(r_wlen);
        end
    end

    assign w_k_m1 = w_k - 1'b1;
    assign w_tap  = w_k_m1 >> 1;

    // Chain of cells; the ends see an always-valid left edge and an empty
    // right edge.
    for (genvar gi = 0; gi < MAX_WINDOW; gi++) begin : g_cell
        t_sample       w_lv;
        logic [KW-1:0] w_la;
        logic          w_lval;
        logic          w_lgt;
        t_sample       w_rv;
        logic [KW-1:0] w_ra;
        logic          w_rval;

        if (gi == 0) begin : g_left_edge
            assign w_lv   = '0;
            assign w_la   = '0;
            assign w_lval = 1'b1;
            assign w_lgt  = 1'b0;
        end else begin : g_left
            assign w_lv   = w_value[gi-1];
            assign w_la   = w_age[gi-1];
            assign w_lval = w_valid[gi-1];
            assign w_lgt  = w_gt[gi-1];
        end

        if (gi == MAX_WINDOW - 1) begin : g_right_edge
            assign w_rv   = '0;
            assign w_ra   = '0;
            assign w_rval = 1'b0;
        end else begin : g_right
            assign w_rv   = w_value[gi+1];
            assign w_ra   = w_age[gi+1];
            assign w_rval = w_valid[gi+1];
        end

        swm_cell #(
            .AGE_W (KW)
        ) u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_cmd         (w_cmd),
            .i_drop_found  (w_drop_found),
            .i_drop_value  (w_drop_value),
            .i_drop_age    (w_drop_age),
            .i_left_value  (w_lv),
            .i_left_age    (w_la),
            .i_left_valid  (w_lval),
            .i_left_gt     (w_lgt),
            .i_right_value (w_rv),
            .i_right_age   (w_ra),
            .i_right_valid (w_rval),
            .o_value       (w_value[gi]),
            .o_age         (w_age[gi]),
            .o_valid       (w_valid[gi]),
            .o_gt          (w_gt[gi])
        );
    end

    // Pick out the outgoing cell, the median cell and the fill test. Ages of
    // valid cells are distinct, so at most one cell matches the drop age.
    always_comb begin
        w_drop_found  = 1'b0;
        w_drop_value  = '0;
        w_median      = '0;
        w_have_result = 1'b0;
        for (int i = 0; i < MAX_WINDOW; i++) begin
            if (w_valid[i] && (w_age[i] == w_drop_age)) begin
                w_drop_found = 1'b1;
                w_drop_value = w_drop_value | w_value[i];
            end
            if (KW'(i) == w_tap) begin
                w_median = w_median | w_value[i];
            end
            if (KW'(i) == w_k_m1) begin
                w_have_result = w_have_result | w_valid[i];
            end
        end
    end

    swm_seq #(
        .KW (KW)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_sample      (i_sample),
        .i_restart     (i_restart),
        .i_k           (w_k),
        .o_cmd         (w_cmd),
        .o_drop_age    (w_drop_age),
        .i_have_result (w_have_result),
        .i_median      (w_median),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_median      (o_median)
    );

endmodule

// File: rtl/swm_checker.sv
// ----------------------------------------------------------------------------
// swm_checker
// Port-level checks for the sliding-window median filter, bound to the top
// level.
// ----------------------------------------------------------------------------
module swm_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic signed [31:0]          i_out_median,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [swm_pkg::APB_AW-1:0]  i_paddr,
    input  logic [swm_pkg::APB_DW-1:0]  i_pwdata,
    input  logic [swm_pkg::APB_DW-1:0]  i_prdata
);
    import swm_pkg::*;

    // A result word waiting to be taken holds its value.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_median))
        else $error("swm: result word changed or vanished while stalled");

    // An accepted word keeps the input closed through the drop and insert steps.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready ##1 !i_in_ready)
        else $error("swm: input accepted again too soon");

    // A new result word is loaded only at the end of an item's work.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> !$past(i_in_ready))
        else $error("swm: result word appeared outside the emit step");

    // A write to the window length reads back in the next cycle.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_SEL_WINDOW_LENGTH)
        |=> (i_paddr[2] != REG_SEL_WINDOW_LENGTH)
            || (i_prdata[WLEN_W-1:0] == $past(i_pwdata[WLEN_W-1:0])))
        else $error("swm: window length readback mismatch");

endmodule

bind sliding_window_median swm_checker u_swm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_valid),
    .i_in_ready   (o_ready),
    .i_out_valid  (o_valid),
    .i_out_ready  (i_ready),
    .i_out_median (o_median),
    .i_psel       (psel),
    .i_penable    (penable),
    .i_pwrite     (pwrite),
    .i_paddr      (paddr),
    .i_pwdata     (pwdata),
    .i_prdata     (prdata)
);

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks sliding_window_median against a cycle-free predictor of the sorted
// window. Directed tests cover the reset window length, the window of one,
// the lower median and equal samples, restart, and window length changes in
// the middle of a sequence. A back-pressure test and a long random stream
// follow, with random idling on both sides and register writes between
// phases.
// ----------------------------------------------------------------------------
module testbench;
    import swm_pkg::*;

    localparam int MAX_WIN         = 64;
    localparam int DRAIN_CYCLES    = 4 + MAX_WIN + 32;
    localparam int STALL_LIMIT     = 5000;
    localparam int TARGET_WORDS    = 1450;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam logic [APB_AW-1:0] ADDR_WINDOW_LENGTH = {REG_SEL_WINDOW_LENGTH, 2'b00};
    localparam t_sample SAMPLE_MIN = 32'sh8000_0000;
    localparam t_sample SAMPLE_MAX = 32'sh7FFF_FFFF;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    t_sample           i_sample;
    logic              i_restart;
    logic              o_valid;
    logic              i_ready;
    t_sample           o_median;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // Predictor state: the sorted window with the age of each cell.
    t_sample           chain_value [MAX_WIN];
    int                chain_age [MAX_WIN];
    int                chain_fill;
    logic [WLEN_W-1:0] window_length_reg;
    t_sample           expected_medians [$];

    int error_count;
    int words_sent;
    int quiet_cycles;
    int hold_request;
    int hold_left;
    bit tx_gap_en;
    bit rx_stall_en;

    sliding_window_median #(
        .MAX_WINDOW (MAX_WIN)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .o_ready   (o_ready),
        .i_sample  (i_sample),
        .i_restart (i_restart),
        .o_valid   (o_valid),
        .i_ready   (i_ready),
        .o_median  (o_median),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 i_clk = ~i_clk;

    // Prints one line per failure and counts it.
    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Zero acts as one; lengths above the chain size saturate.
    function automatic int window_span(input logic [WLEN_W-1:0] len);
        if (len == 0) begin
            return 1;
        end
        return (len > MAX_WIN) ? MAX_WIN : int'(len);
    endfunction

    // Ages the window, drops cells that left it, inserts the new sample in
    // sorted order, and queues the median once the window is full.
    function automatic void predict_median(input t_sample value, input logic restart);
        int span;
        int kept;
        int pos;
        int age;
        span = window_span(window_length_reg);
        kept = 0;
        if (restart) begin
            chain_fill = 0;
        end
        for (int i = 0; i < chain_fill; i++) begin
            age = chain_age[i] + 1;
            if (age < span) begin
                chain_value[kept] = chain_value[i];
                chain_age[kept]   = age;
                kept++;
            end
        end
        chain_fill = kept;
        if (chain_fill < MAX_WIN) begin
            pos = chain_fill;
            while (pos > 0 && chain_value[pos-1] > value) begin
                chain_value[pos] = chain_value[pos-1];
                chain_age[pos]   = chain_age[pos-1];
                pos--;
            end
            chain_value[pos] = value;
            chain_age[pos]   = 0;
            chain_fill++;
        end
        if (chain_fill >= span) begin
            expected_medians.push_back(chain_value[(span - 1) / 2]);
        end
    endfunction

    // Offers one word, with an optional idle gap first, and waits until the
    // block takes it.
    task automatic send_sample(input t_sample value, input logic restart);
        if (tx_gap_en && $urandom_range(99) < 28) begin
            @(negedge i_clk);
            i_valid = 1'b0;
            repeat ($urandom_range(6)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   = 1'b1;
        i_sample  = value;
        i_restart = restart;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        predict_median(value, restart);
        words_sent++;
    endtask

    task automatic release_input();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // Waits for every expected word, then lets a word that yields no median
    // finish inside the block.
    task automatic wait_block_idle();
        release_input();
        while (expected_medians.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Writes the window length while the block is idle and reads it back.
    task automatic write_window_length(input logic [WLEN_W-1:0] len);
        wait_block_idle();
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = ADDR_WINDOW_LENGTH;
        pwdata  = {{(APB_DW-WLEN_W){1'b0}}, len};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (prdata[WLEN_W-1:0] !== len) begin
            report_error($sformatf("window_length read %0d, wrote %0d",
                                   prdata[WLEN_W-1:0], len));
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        window_length_reg = len;
    endtask

    // Extremes and small values come often so that equal samples are common.
    function automatic t_sample pick_sample();
        case ($urandom_range(9))
            0: return SAMPLE_MIN;
            1: return SAMPLE_MAX;
            2, 3: return $urandom_range(6) - 3;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [WLEN_W-1:0] pick_window_length();
        case ($urandom_range(15))
            0: return '0;
            1: return 7'd64;
            2: return WLEN_W'($urandom_range(127, 65));
            3: return WLEN_W'($urandom_range(63, 10));
            default: return WLEN_W'($urandom_range(9, 1));
        endcase
    endfunction

    // Window length from reset, with the sample extremes.
    task automatic test_reset_window();
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(0, 1'b0);
        send_sample(-1, 1'b0);
        wait_block_idle();
    endtask

    // Zero acts as a window of one; then a true window of one.
    task automatic test_window_of_one();
        write_window_length('0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        write_window_length(7'd1);
        send_sample(1, 1'b1);
        send_sample(-1, 1'b0);
    endtask

    // Even window gives the lower median; an outgoing sample removes only
    // one of several equal cells.
    task automatic test_lower_median_and_duplicates();
        write_window_length(7'd4);
        send_sample(2, 1'b1);
        send_sample(2, 1'b0);
        send_sample(2, 1'b0);
        send_sample(8, 1'b0);
        send_sample(8, 1'b0);
        send_sample(8, 1'b0);
    endtask

    // Restart empties the window so the next median waits for a full one.
    task automatic test_restart();
        write_window_length(7'd3);
        send_sample(1, 1'b1);
        send_sample(2, 1'b0);
        send_sample(3, 1'b0);
        send_sample(40, 1'b1);
        send_sample(50, 1'b0);
        send_sample(60, 1'b0);
    endtask

    // Shrinking mid-sequence gives a median at once; growing delays it.
    task automatic test_window_change();
        write_window_length(7'd5);
        send_sample(10, 1'b1);
        send_sample(20, 1'b0);
        send_sample(30, 1'b0);
        send_sample(40, 1'b0);
        send_sample(50, 1'b0);
        write_window_length(7'd2);
        send_sample(5, 1'b0);
        write_window_length(7'd4);
        send_sample(6, 1'b0);
        send_sample(7, 1'b0);
    endtask

    // The receiver holds off while words keep coming, so the block stalls
    // its input.
    task automatic test_backpressure();
        write_window_length(7'd2);
        tx_gap_en    = 1'b0;
        hold_request = HOLD_OFF_CYCLES;
        repeat (40) send_sample(pick_sample(), 1'b0);
        tx_gap_en = 1'b1;
        wait_block_idle();
    endtask

    // Phases of random words, each with its own window length and idling.
    task automatic test_random_stream();
        int                phase;
        int                span;
        int                burst;
        logic [WLEN_W-1:0] len;
        phase = 0;
        while (words_sent < TARGET_WORDS) begin
            case (phase)
                0: len = 7'd127;
                1: len = 7'd64;
                default: len = pick_window_length();
            endcase
            write_window_length(len);
            // Phase two runs with no idling at all.
            tx_gap_en   = (phase != 2) && ($urandom_range(3) != 0);
            rx_stall_en = (phase != 2) && ($urandom_range(3) != 0);
            span  = window_span(len);
            burst = (span > 9) ? span + $urandom_range(60, 20) : $urandom_range(80, 30);
            repeat (burst) begin
                send_sample(pick_sample(), $urandom_range(999) < ((span > 9) ? 3 : 40));
            end
            phase++;
        end
        tx_gap_en   = 1'b1;
        rx_stall_en = 1'b1;
    endtask

    // Receiver: long hold-off on request, otherwise random or no stalls.
    always @(negedge i_clk) begin
        if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left != 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else if (rx_stall_en) begin
            i_ready <= ($urandom_range(99) >= 28);
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Compares each median word with the oldest expectation.
    always @(posedge i_clk) begin
        t_sample want;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_medians.size() == 0) begin
                report_error($sformatf("median %0d with no word expected", o_median));
            end else begin
                want = expected_medians.pop_front();
                if (o_median !== want) begin
                    report_error($sformatf("median %0d, expected %0d", o_median, want));
                end
            end
        end
    end

    // Watchdog on cycles in which no word or register access completes.
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("Timeout: nothing accepted for %0d cycles", STALL_LIMIT);
                $display("sliding_window_median verification failed");
                $finish;
            end
        end
    end

    initial begin
        i_clk        = 1'b0;
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_sample     = '0;
        i_restart    = 1'b0;
        i_ready      = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        error_count  = 0;
        words_sent   = 0;
        quiet_cycles = 0;
        hold_request = 0;
        hold_left    = 0;
        tx_gap_en    = 1'b1;
        rx_stall_en  = 1'b1;
        chain_fill   = 0;
        window_length_reg = WLEN_RESET;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_reset_window();
        test_window_of_one();
        test_lower_median_and_duplicates();
        test_restart();
        test_window_change();
        test_backpressure();
        test_random_stream();
        wait_block_idle();

        if (error_count == 0) begin
            $display("sliding_window_median verification clean");
        end else begin
            $display("sliding_window_median verification failed");
        end
        $finish;
    end

endmodule
